// ----- sv/cmfd_pkg.sv -----
// ----------------------------------------------------------------------------
// cmfd_pkg
// Shared types and constants of the counter-marked frame deframer.
// ----------------------------------------------------------------------------
package cmfd_pkg;

    localparam int FRAME_BYTES_DEF = 5;
    localparam int SAMPLE_BYTES    = 5;   // marker plus two 16-bit samples
    localparam int FIFO_DEPTH_DEF  = 4;

    localparam logic [7:0]  MARKER_MAX_RST = 8'd250;
    localparam logic [15:0] SAMPLE_OFFSET  = 16'h8000;

    typedef struct packed {
        logic        [7:0]  marker;
        logic signed [15:0] chan_a;
        logic signed [15:0] chan_b;
        logic        [31:0] number;
        logic               last;
    } t_result;

    // Results written into the output queue in one cycle (none, one or two).
    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
    } t_res_wr;

endpackage

// ----- sv/cmfd_core.sv -----
// ----------------------------------------------------------------------------
// cmfd_core
// Input register, byte history window, lock search and frame emission.
// ----------------------------------------------------------------------------
module cmfd_core #(
    parameter int FRAME_BYTES = cmfd_pkg::FRAME_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_wdata,
    output cmfd_pkg::t_res_wr o_wr
);
    import cmfd_pkg::*;

    localparam int HIST   = 2 * FRAME_BYTES;
    localparam int FILL_W = $clog2(HIST + 1);
    localparam int PH_W   = $clog2(FRAME_BYTES);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic [7:0]        r_hist [0:HIST-1];   // index 0 is the newest byte
    logic [FILL_W-1:0] r_fill;
    logic              r_locked;
    logic [PH_W-1:0]   r_phase;
    logic [31:0]       r_count;
    logic [7:0]        r_marker_max;

    logic [7:0] w_f0 [0:SAMPLE_BYTES-1];
    logic [7:0] w_f1 [0:SAMPLE_BYTES-1];
    logic       w_lock_hit;
    logic       w_emit;
    t_result    w_frame0;
    t_result    w_frame1;

    function automatic logic [7:0] succ(input logic [7:0] m, input logic [7:0] mx);
        return (m >= mx) ? 8'd0 : m + 8'd1;
    endfunction

    // Bytes beyond the frame length read as zero.
    for (genvar k = 0; k < SAMPLE_BYTES; k++) begin : g_byte
        if (k < FRAME_BYTES) begin : g_in
            assign w_f0[k] = r_hist[HIST-1-k];
            assign w_f1[k] = r_hist[FRAME_BYTES-1-k];
        end else begin : g_zero
            assign w_f0[k] = 8'd0;
            assign w_f1[k] = 8'd0;
        end
    end

    always_comb begin
        w_lock_hit = r_in_valid && !r_locked && (r_fill == FILL_W'(HIST))
                  && (r_hist[FRAME_BYTES-1] == succ(r_hist[HIST-1], r_marker_max))
                  && (r_in_byte == succ(r_hist[FRAME_BYTES-1], r_marker_max));
        w_emit = r_in_valid && r_locked && (r_phase == '0)
              && (r_in_byte == succ(r_hist[FRAME_BYTES-1], r_marker_max));

        w_frame0.marker = w_f0[0];
        w_frame0.chan_a = signed'({w_f0[1], w_f0[2]} ^ SAMPLE_OFFSET);
        w_frame0.chan_b = signed'({w_f0[3], w_f0[4]} ^ SAMPLE_OFFSET);
        w_frame0.number = r_count + 32'd1;
        w_frame0.last   = 1'b0;

        w_frame1.marker = w_f1[0];
        w_frame1.chan_a = signed'({w_f1[1], w_f1[2]} ^ SAMPLE_OFFSET);
        w_frame1.chan_b = signed'({w_f1[3], w_f1[4]} ^ SAMPLE_OFFSET);
        w_frame1.number = r_count + (w_lock_hit ? 32'd2 : 32'd1);
        w_frame1.last   = 1'b1;

        o_wr.num = 2'd0;
        o_wr.r0  = w_frame1;
        o_wr.r1  = w_frame1;
        if (w_lock_hit) begin
            o_wr.num = 2'd2;
            o_wr.r0  = w_frame0;
        end else if (w_emit) begin
            o_wr.num = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_fill       <= '0;
            r_locked     <= 1'b0;
            r_phase      <= '0;
            r_count      <= '0;
            r_marker_max <= MARKER_MAX_RST;
        end else begin
            r_in_valid <= i_valid;
            if (i_cfg_we) begin
                r_marker_max <= i_cfg_wdata;
            end
            if (r_in_valid) begin
                if (r_fill != FILL_W'(HIST)) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
                if (w_lock_hit) begin
                    r_locked <= 1'b1;
                    r_phase  <= PH_W'(1);
                    r_count  <= r_count + 32'd2;
                end else if (r_locked) begin
                    r_phase <= (r_phase == PH_W'(FRAME_BYTES - 1)) ? '0 : r_phase + PH_W'(1);
                    if (w_emit) begin
                        r_count <= r_count + 32'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_in_byte <= i_byte;
        end
        if (r_in_valid) begin
            r_hist[0] <= r_in_byte;
            for (int i = 1; i < HIST; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

endmodule

// ----- sv/cmfd_out_fifo.sv -----
// ----------------------------------------------------------------------------
// cmfd_out_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module cmfd_out_fifo #(
    parameter int DEPTH = cmfd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cmfd_pkg::t_res_wr          i_wr,
    input  logic                       i_pop,
    output logic                       o_valid,
    output cmfd_pkg::t_result          o_head,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import cmfd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result          r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] w_wr_ptr1;
    logic             w_pop;

    assign w_wr_ptr1 = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
    assign w_pop     = i_pop && (r_count != '0);
    assign o_valid   = (r_count != '0);
    assign o_head    = r_mem[r_rd_ptr];
    assign o_count   = r_count;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                             input logic [1:0] n);
        logic [PTR_W:0] s;
        s = {1'b0, p} + (PTR_W+1)'(n);
        if (s >= (PTR_W+1)'(DEPTH)) begin
            s = s - (PTR_W+1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= adv(r_wr_ptr, i_wr.num);
            if (w_pop) begin
                r_rd_ptr <= adv(r_rd_ptr, 2'd1);
            end
            r_count <= r_count + CNT_W'(i_wr.num) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_wr.r0;
        end
        if (i_wr.num == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_wr.r1;
        end
    end

endmodule

// ----- sv/counter_marked_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// counter_marked_frame_deframer
// Finds lock on a marker-counted byte stream and emits the decoded frames.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word
//  s_axis    in         raw stream byte
//  m_axis    out        marker, channel a, channel b, frame number; tlast
//  cfg       in         marker_max write, no read-back
//
//  One byte is taken every cycle while s_axis_tready is high. A byte reaches
//  the input register, then the history window and lock logic write zero, one
//  or two results into a four-entry queue the next cycle; a result can leave
//  in the cycle after that. The lock byte yields two results, which leave
//  one at a time. s_axis_tready falls when the queue cannot hold the results
//  of the word in flight and the worst case of the next, even with no stall.
//  Reset is synchronous and clears lock, history fill, phase and count.
// ----------------------------------------------------------------------------
module counter_marked_frame_deframer #(
    parameter int FRAME_BYTES = cmfd_pkg::FRAME_BYTES_DEF,
    parameter int FIFO_DEPTH  = cmfd_pkg::FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // frame_marker, channel_a, channel_b, frame_number
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import cmfd_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W = CNT_W + 2;

    t_res_wr          w_wr;
    t_result          w_head;
    logic [CNT_W-1:0] w_count;
    logic [SUM_W-1:0] w_need;

    // Room for the results of the word in the input register and of a new one.
    assign w_need        = SUM_W'(w_count) + SUM_W'(w_wr.num) + SUM_W'(2);
    assign s_axis_tready = (w_need <= SUM_W'(FIFO_DEPTH));

    cmfd_core #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid && s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_wr       (w_wr)
    );

    cmfd_out_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (w_wr),
        .i_pop  (m_axis_tready),
        .o_valid(m_axis_tvalid),
        .o_head (w_head),
        .o_count(w_count)
    );

    assign m_axis_tdata = {w_head.number, w_head.chan_b, w_head.chan_a, w_head.marker};
    assign m_axis_tlast = w_head.last;

endmodule
